### hdl/iltp_pkg.sv
// Shared types, codes and the opcode length table of the instruction length
// and target predecoder. No dependencies; used by the top-level module.
package iltp_pkg;

  localparam int unsigned MaxInsnBytes = 8;
  localparam int unsigned IdxW         = $clog2(MaxInsnBytes);

  localparam logic [7:0] PrefixByte = 8'hFE;

  // Opcode groups as reported on the result channel.
  typedef enum logic [3:0] {
    GRP_SJMP    = 4'd0,
    GRP_SCALL   = 4'd1,
    GRP_JBC     = 4'd2,
    GRP_JBS     = 4'd3,
    GRP_CONDJMP = 4'd4,
    GRP_FX      = 4'd5,
    GRP_EX      = 4'd6,
    GRP_CX      = 4'd7,
    GRP_LOW     = 4'd8,
    GRP_MIDDLE  = 4'd9
  } grp_e;

  // Kind of the reference word.
  typedef enum logic [2:0] {
    REF_NONE    = 3'd0,
    REF_JUMP    = 3'd1,
    REF_CALL    = 3'd2,
    REF_DATA    = 3'd3,
    REF_POINTER = 3'd4
  } ref_e;

  // Addressing modes taken from the two low opcode bits.
  localparam logic [1:0] ModeDirect    = 2'd0;
  localparam logic [1:0] ModeImmediate = 2'd1;
  localparam logic [1:0] ModeIndirect  = 2'd2;
  localparam logic [1:0] ModeIndexed   = 2'd3;

  // Special opcodes.
  localparam logic [7:0] OpDjnz  = 8'hE0;
  localparam logic [7:0] OpDjnzw = 8'hE1;
  localparam logic [7:0] OpLjmp  = 8'hE7;
  localparam logic [7:0] OpLcall = 8'hEF;
  localparam logic [7:0] OpBmov  = 8'hC1;
  localparam logic [7:0] OpCmpl  = 8'hC5;

  // Decoded length table entry: len zero marks an unknown opcode, ext adds a
  // byte when the byte after the opcode is odd.
  typedef struct packed {
    logic       ext;
    logic [2:0] len;
  } len_t;

  localparam logic signed [3:0] LenRom [256] = '{
     2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3, 3, 3, 3,
     0, 2, 2, 2, 0, 2, 2, 2, 3, 3, 3, 0, 0, 0, 0, 0,
     2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
     3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3,
     4, 5, 4,-5, 4, 5, 4,-5, 4, 5, 4,-5, 4, 5, 4,-5,
     4, 4, 4,-5, 4, 4, 4,-5, 4, 4, 4,-5, 4, 4, 4,-5,
     3, 4, 3,-4, 3, 4, 3,-4, 3, 4, 3,-4, 3, 4, 3,-4,
     3, 3, 3,-4, 3, 3, 3,-4, 3, 3, 3,-4, 3, 3, 3,-4,
     3, 4, 3,-4, 3, 4, 3,-4, 3, 4, 3,-4, 3, 4, 3,-4,
     3, 3, 3,-4, 3, 3, 3,-4, 3, 3, 3,-4, 3, 3, 3,-4,
     3, 4, 3,-4, 3, 4, 3,-4, 3, 4, 3,-4, 3, 3, 3,-4,
     3, 3, 3,-4, 3, 3, 3,-4, 3, 3, 3,-4, 3, 3, 3,-4,
     3, 3, 3,-4, 3, 3, 3,-4, 2, 3, 2,-3, 2, 0, 2,-3,
     2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
     3, 3, 0, 2, 0, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0, 3,
     1, 0, 1, 1, 1, 1, 2, 0, 1, 1, 1, 1, 1, 1,-7, 1
  };

  function automatic len_t len_lookup(input logic [7:0] op);
    logic signed [3:0] e;
    len_t r;
    e     = LenRom[op];
    r.ext = e[3];
    r.len = e[3] ? 3'(-e) : e[2:0];
    return r;
  endfunction

  function automatic grp_e group_of(input logic [7:0] op);
    grp_e g;
    priority if (op[7:3] == 5'b00100) g = GRP_SJMP;
    else if (op[7:3] == 5'b00101) g = GRP_SCALL;
    else if (op[7:3] == 5'b00110) g = GRP_JBC;
    else if (op[7:3] == 5'b00111) g = GRP_JBS;
    else if (op[7:4] == 4'hD) g = GRP_CONDJMP;
    else if (op[7:4] == 4'hF) g = GRP_FX;
    else if (op[7:4] == 4'hE) g = GRP_EX;
    else if (op[7:4] == 4'hC) g = GRP_CX;
    else if (op[7:5] == 3'b000) g = GRP_LOW;
    else g = GRP_MIDDLE;
    return g;
  endfunction

endpackage

### hdl/insn_length_and_target_predecoder_unit.sv
// Instruction length and target predecoder, top level.
// Depends on iltp_pkg for the length table, group and reference codes.
//
// Usage: code bytes enter one per transaction on the input channel
// (in_valid_i, in_stall_o, code_byte_i). The block tracks instruction
// boundaries, including an optional 0xFE signed prefix, and emits one record
// per finished instruction on the result channel (out_valid_o, out_stall_i
// and the record fields). Prefix bytes and non-final bytes give no record.
// Throughput: one code byte per cycle while in_stall_o is low. Every byte is
// decoded by a single pass of logic (length table lookup, group decode and
// one 16-bit target add) between the byte state registers and the result
// register, so the record for an instruction appears in the cycle after
// its last byte is accepted. The result register is the only buffer: a new
// byte is taken whenever that register is empty or is being drained in the
// same cycle. While the receiver stalls with a record pending, in_stall_o is
// high and the pending record holds steady.
// Reset clears all control state and sets the start address to zero. A write
// of start_address through the APB-style port (byte address 0) restarts
// decoding at that address; it is meant to be done only while the block is
// idle. Reads of address 0 return start_address.
module insn_length_and_target_predecoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Code byte channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  // Record channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] insn_address_o,
  output logic [7:0]  opcode_value_o,
  output logic        signed_prefix_o,
  output logic [3:0]  total_length_o,
  output logic        known_opcode_o,
  output logic [3:0]  opcode_group_o,
  output logic [1:0]  address_mode_o,
  output logic        byte_operation_o,
  output logic [2:0]  reference_kind_o,
  output logic [15:0] reference_value_o
);

  localparam int unsigned IdxW = iltp_pkg::IdxW;
  localparam int unsigned PhW  = IdxW + 1;

  // Decode state.
  logic [15:0]     start_addr_q;
  logic [IdxW-1:0] phase_q, phase_d;
  logic [PhW-1:0]  exp_len_q, exp_len_d;
  logic            ext_q, ext_d;
  logic            prefix_q, prefix_d;
  logic [15:0]     cur_addr_q, cur_addr_d;
  logic [15:0]     first_addr_q, first_addr_d;
  logic [7:0]      bytes_q [iltp_pkg::MaxInsnBytes];

  // Result register.
  logic        out_valid_q;
  logic [15:0] addr_q;
  logic [7:0]  op_q;
  logic        pfx_q;
  logic [3:0]  tlen_q;
  logic        known_q;
  logic [3:0]  grp_q;
  logic [1:0]  mode_q;
  logic        bop_q;
  logic [2:0]  kind_q;
  logic [15:0] val_q;

  logic cfg_wr;
  logic in_accept;

  // Combinational record.
  logic                 emit;
  logic                 store_byte;
  logic                 known;
  logic [7:0]           view [4];
  logic [7:0]           op;
  iltp_pkg::grp_e       grp;
  logic [1:0]           mode;
  logic                 bop;
  iltp_pkg::ref_e       kind;
  logic [15:0]          val;
  logic [15:0]          nxt;
  logic [3:0]           tlen;

  assign pready    = 1'b1;
  assign prdata    = {16'b0, start_addr_q};
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;

  // Byte tracking: next phase, length and addresses for the incoming byte.
  always_comb begin
    iltp_pkg::len_t       le;
    logic [PhW-1:0]       ph_next;
    phase_d      = phase_q;
    exp_len_d    = exp_len_q;
    ext_d        = ext_q;
    prefix_d     = prefix_q;
    first_addr_d = first_addr_q;
    cur_addr_d   = cur_addr_q + 16'd1;
    emit         = 1'b0;
    store_byte   = 1'b1;
    known        = 1'b1;
    le           = iltp_pkg::len_lookup(code_byte_i);
    ph_next      = PhW'(phase_q) + PhW'(1);
    if (phase_q == '0) begin
      if (!prefix_q) begin
        first_addr_d = cur_addr_q;
      end
      if (code_byte_i == iltp_pkg::PrefixByte && !prefix_q) begin
        prefix_d   = 1'b1;
        store_byte = 1'b0;
      end else if (le.len == 3'd0) begin
        exp_len_d = PhW'(1);
        known     = 1'b0;
        emit      = 1'b1;
      end else begin
        exp_len_d = PhW'(le.len);
        ext_d     = le.ext;
        phase_d   = IdxW'(1);
        emit      = (PhW'(1) >= PhW'(le.len));
      end
    end else begin
      if (phase_q == IdxW'(1) && ext_q && code_byte_i[0]) begin
        exp_len_d = exp_len_q + PhW'(1);
      end
      phase_d = ph_next[IdxW-1:0];
      emit    = (ph_next >= exp_len_d) || ph_next[IdxW];
    end
    if (emit) begin
      phase_d  = '0;
      prefix_d = 1'b0;
    end
  end

  // The first four instruction bytes as seen with the incoming byte in place.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      view[k] = (phase_q == IdxW'(k)) ? code_byte_i : bytes_q[k];
    end
  end

  // Record fields: group, addressing mode and the reference word.
  always_comb begin
    logic [15:0] off;
    logic        add_nxt;
    logic [PhW-1:0] long_len;
    op       = view[0];
    grp      = iltp_pkg::group_of(op);
    nxt      = cur_addr_d;
    mode     = iltp_pkg::ModeDirect;
    bop      = 1'b0;
    kind     = iltp_pkg::REF_NONE;
    off      = '0;
    add_nxt  = 1'b0;
    long_len = op[3] ? PhW'(4) : PhW'(5);
    if (known) begin
      unique case (grp)
        iltp_pkg::GRP_SJMP, iltp_pkg::GRP_SCALL: begin
          kind    = (grp == iltp_pkg::GRP_SJMP) ? iltp_pkg::REF_JUMP : iltp_pkg::REF_CALL;
          off     = {{6{op[2]}}, op[1:0], view[1]};
          add_nxt = 1'b1;
        end
        iltp_pkg::GRP_JBC, iltp_pkg::GRP_JBS: begin
          kind    = iltp_pkg::REF_JUMP;
          off     = {{8{view[2][7]}}, view[2]};
          add_nxt = 1'b1;
        end
        iltp_pkg::GRP_CONDJMP: begin
          kind    = iltp_pkg::REF_JUMP;
          off     = {{8{view[1][7]}}, view[1]};
          add_nxt = 1'b1;
        end
        iltp_pkg::GRP_EX: begin
          if (op == iltp_pkg::OpDjnz || op == iltp_pkg::OpDjnzw) begin
            kind    = iltp_pkg::REF_JUMP;
            off     = {{8{view[2][7]}}, view[2]};
            add_nxt = 1'b1;
          end else if (op == iltp_pkg::OpLjmp || op == iltp_pkg::OpLcall) begin
            kind    = (op == iltp_pkg::OpLjmp) ? iltp_pkg::REF_JUMP : iltp_pkg::REF_CALL;
            off     = {view[2], view[1]};
            add_nxt = 1'b1;
          end
        end
        iltp_pkg::GRP_CX: begin
          mode = op[1:0];
          bop  = op[4];
          if (op != iltp_pkg::OpBmov && op != iltp_pkg::OpCmpl &&
              mode == iltp_pkg::ModeIndexed && exp_len_d == long_len) begin
            kind = iltp_pkg::REF_POINTER;
            off  = {view[3], view[2]};
          end
        end
        iltp_pkg::GRP_MIDDLE: begin
          mode = op[1:0];
          bop  = op[4];
          if (mode == iltp_pkg::ModeImmediate) begin
            if (!op[4] && ((op & 8'hAC) != 8'hAC)) begin
              kind = iltp_pkg::REF_DATA;
              off  = {view[2], view[1]};
            end
          end else if (mode == iltp_pkg::ModeIndexed && view[1][0]) begin
            kind = iltp_pkg::REF_POINTER;
            off  = {view[3], view[2]};
          end
        end
        default: begin
        end
      endcase
    end
    val  = add_nxt ? (nxt + off) : off;
    tlen = 4'(exp_len_d) + {3'b0, prefix_q};
  end

  // Decode state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= '0;
      phase_q      <= '0;
      exp_len_q    <= '0;
      ext_q        <= 1'b0;
      prefix_q     <= 1'b0;
      cur_addr_q   <= '0;
      first_addr_q <= '0;
    end else if (cfg_wr) begin
      start_addr_q <= pwdata[15:0];
      phase_q      <= '0;
      exp_len_q    <= '0;
      prefix_q     <= 1'b0;
      cur_addr_q   <= pwdata[15:0];
    end else if (in_accept) begin
      phase_q      <= phase_d;
      exp_len_q    <= emit ? '0 : exp_len_d;
      ext_q        <= ext_d;
      prefix_q     <= prefix_d;
      cur_addr_q   <= cur_addr_d;
      first_addr_q <= first_addr_d;
    end
  end

  // Instruction byte store, written at the current phase.
  always_ff @(posedge clk_i) begin
    if (in_accept && store_byte) begin
      bytes_q[phase_q] <= code_byte_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      addr_q  <= first_addr_d;
      op_q    <= op;
      pfx_q   <= prefix_q;
      tlen_q  <= tlen;
      known_q <= known;
      grp_q   <= grp;
      mode_q  <= mode;
      bop_q   <= bop;
      kind_q  <= kind;
      val_q   <= (kind == iltp_pkg::REF_NONE) ? 16'd0 : val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign insn_address_o    = addr_q;
  assign opcode_value_o    = op_q;
  assign signed_prefix_o   = pfx_q;
  assign total_length_o    = tlen_q;
  assign known_opcode_o    = known_q;
  assign opcode_group_o    = grp_q;
  assign address_mode_o    = mode_q;
  assign byte_operation_o  = bop_q;
  assign reference_kind_o  = kind_q;
  assign reference_value_o = val_q;

  // A record always covers between one and nine bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (total_length_o >= 4'd1 && total_length_o <= 4'd9))
    else $error("record length out of range");

  // Unknown opcodes carry no mode, byte bit or reference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !known_opcode_o) |->
      (reference_kind_o == iltp_pkg::REF_NONE && address_mode_o == 2'd0 &&
       !byte_operation_o))
    else $error("unknown opcode with decoded fields");

  // A record without reference has a zero reference word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reference_kind_o == iltp_pkg::REF_NONE) |->
      (reference_value_o == 16'd0))
    else $error("reference word set without reference kind");

  // Writing the start address restarts decoding at an instruction boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (phase_q == '0 && !prefix_q && cur_addr_q == start_addr_q))
    else $error("restart did not clear decode state");

endmodule

### tb/sv/tb_insn_length_and_target_predecoder_unit.sv
// Self-checking testbench for insn_length_and_target_predecoder_unit: drives
// code bytes and APB writes, predicts every instruction record and checks it.
// Depends on iltp_pkg for the group and reference codes and the prefix byte.
module tb_insn_length_and_target_predecoder_unit;

  // Register map of the configuration port. The second address holds no
  // register, so a write there must leave the start address alone.
  localparam logic [2:0] AddrStartAddress = 3'd0;
  localparam logic [2:0] AddrUnmapped     = 3'd4;

  // A run ends as a failure after this many cycles without a transaction.
  localparam int QuietLimit = 4000;

  // Opcodes with special reference handling, drawn more often than chance.
  localparam int NumHotOps = 18;
  localparam logic [8*NumHotOps-1:0] HotOps = {
    8'hE0, 8'hE1, 8'hE7, 8'hEF, 8'hC1, 8'hC5, 8'hC3, 8'hC7, 8'hCB,
    8'hCF, 8'hAD, 8'hBD, 8'h41, 8'h43, 8'h2F, 8'h3F, 8'hDF, 8'hFE
  };

  // One instruction record as it leaves the block.
  typedef struct packed {
    logic [15:0]    insn_address;
    logic [7:0]     opcode;
    logic           prefixed;
    logic [3:0]     length;
    logic           known;
    iltp_pkg::grp_e grp;
    logic [1:0]     mode;
    logic           byte_op;
    iltp_pkg::ref_e kind;
    logic [15:0]    value;
  } insn_record_t;

  // Tracks instruction boundaries over the accepted code bytes, works out the
  // record of each finished instruction and checks the records the block
  // sends against them in order.
  class insn_record_scoreboard;
    logic [15:0]  start_addr;
    logic [15:0]  cur_addr;
    logic [15:0]  first_addr;
    logic [7:0]   insn[8];
    int           phase;
    int           need;
    bit           prefixed;
    insn_record_t pending_records[$];
    int           errors;

    function new();
      start_addr = '0;
      cur_addr   = '0;
      first_addr = '0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      phase    = 0;
      need     = 0;
      prefixed = 1'b0;
    endfunction

    function void write_start(logic [15:0] addr);
      start_addr = addr;
      cur_addr   = addr;
      restart();
    endfunction

    // Length table, one row of sixteen 4-bit entries per high opcode nibble,
    // entry 0 leftmost. Zero means unknown; a negative entry -k means k bytes
    // plus one when the byte after the opcode is odd.
    static function logic [3:0] len_entry(logic [7:0] op);
      logic [63:0] row;
      int          idx;
      idx = op[3:0];
      case (op[7:4])
        4'h0: row = 64'h2222_2222_3333_3333;
        4'h1: row = 64'h0222_0222_3330_0000;
        4'h2: row = 64'h2222_2222_2222_2222;
        4'h3: row = 64'h3333_3333_3333_3333;
        4'h4: row = 64'h454B_454B_454B_454B;
        4'h5: row = 64'h444B_444B_444B_444B;
        4'h6: row = 64'h343C_343C_343C_343C;
        4'h7: row = 64'h333C_333C_333C_333C;
        4'h8: row = 64'h343C_343C_343C_343C;
        4'h9: row = 64'h333C_333C_333C_333C;
        4'hA: row = 64'h343C_343C_343C_333C;
        4'hB: row = 64'h333C_333C_333C_333C;
        4'hC: row = 64'h333C_333C_232D_202D;
        4'hD: row = 64'h2222_2222_2222_2222;
        4'hE: row = 64'h3302_0003_0000_0003;
        default: row = 64'h1011_1120_1111_1191;
      endcase
      return row[63-4*idx -: 4];
    endfunction

    static function iltp_pkg::grp_e group_for(logic [7:0] op);
      case (op[7:4])
        4'h0, 4'h1: return iltp_pkg::GRP_LOW;
        4'h2: return op[3] ? iltp_pkg::GRP_SCALL : iltp_pkg::GRP_SJMP;
        4'h3: return op[3] ? iltp_pkg::GRP_JBS : iltp_pkg::GRP_JBC;
        4'hC: return iltp_pkg::GRP_CX;
        4'hD: return iltp_pkg::GRP_CONDJMP;
        4'hE: return iltp_pkg::GRP_EX;
        4'hF: return iltp_pkg::GRP_FX;
        default: return iltp_pkg::GRP_MIDDLE;
      endcase
    endfunction

    // Builds the record of the instruction held in insn[] and queues it.
    function void finish_insn(bit known);
      insn_record_t r;
      logic [7:0]   op;
      logic [15:0]  disp;
      op             = insn[0];
      r.insn_address = first_addr;
      r.opcode       = op;
      r.prefixed     = prefixed;
      r.length       = 4'(need + int'(prefixed));
      r.known        = known;
      r.grp          = group_for(op);
      r.mode         = iltp_pkg::ModeDirect;
      r.byte_op      = 1'b0;
      r.kind         = iltp_pkg::REF_NONE;
      r.value        = '0;
      if (known) begin
        case (r.grp)
          iltp_pkg::GRP_SJMP, iltp_pkg::GRP_SCALL: begin
            // 11-bit displacement: opcode bit 2 is the sign, bits 1..0 the top.
            disp    = {{6{op[2]}}, op[1:0], insn[1]};
            r.kind  = (r.grp == iltp_pkg::GRP_SJMP) ? iltp_pkg::REF_JUMP
                                                     : iltp_pkg::REF_CALL;
            r.value = cur_addr + disp;
          end
          iltp_pkg::GRP_JBC, iltp_pkg::GRP_JBS: begin
            r.kind  = iltp_pkg::REF_JUMP;
            r.value = cur_addr + {{8{insn[2][7]}}, insn[2]};
          end
          iltp_pkg::GRP_CONDJMP: begin
            r.kind  = iltp_pkg::REF_JUMP;
            r.value = cur_addr + {{8{insn[1][7]}}, insn[1]};
          end
          iltp_pkg::GRP_EX: begin
            if (op == iltp_pkg::OpDjnz || op == iltp_pkg::OpDjnzw) begin
              r.kind  = iltp_pkg::REF_JUMP;
              r.value = cur_addr + {{8{insn[2][7]}}, insn[2]};
            end else if (op == iltp_pkg::OpLjmp || op == iltp_pkg::OpLcall) begin
              r.kind  = (op == iltp_pkg::OpLjmp) ? iltp_pkg::REF_JUMP
                                                 : iltp_pkg::REF_CALL;
              r.value = cur_addr + {insn[2], insn[1]};
            end
          end
          iltp_pkg::GRP_CX: begin
            r.mode    = op[1:0];
            r.byte_op = op[4];
            // Only the long indexed form of st/stb/push/pop carries a word.
            if (op != iltp_pkg::OpBmov && op != iltp_pkg::OpCmpl &&
                op[1:0] == iltp_pkg::ModeIndexed &&
                need == (op[3] ? 4 : 5)) begin
              r.kind  = iltp_pkg::REF_POINTER;
              r.value = {insn[3], insn[2]};
            end
          end
          iltp_pkg::GRP_MIDDLE: begin
            r.mode    = op[1:0];
            r.byte_op = op[4];
            if (op[1:0] == iltp_pkg::ModeImmediate) begin
              // Word immediates only; the sign and zero extending byte loads
              // take a byte operand.
              if (!op[4] && (op & 8'hAC) != 8'hAC) begin
                r.kind  = iltp_pkg::REF_DATA;
                r.value = {insn[2], insn[1]};
              end
            end else if (op[1:0] == iltp_pkg::ModeIndexed && insn[1][0]) begin
              r.kind  = iltp_pkg::REF_POINTER;
              r.value = {insn[3], insn[2]};
            end
          end
          default: ;
        endcase
      end
      pending_records.push_back(r);
      restart();
    endfunction

    // Advances the boundary tracking by one accepted code byte.
    function void note_code_byte(logic [7:0] b);
      logic [3:0] e;
      if (phase == 0) begin
        if (!prefixed) first_addr = cur_addr;
        cur_addr = cur_addr + 16'd1;
        if (b == iltp_pkg::PrefixByte && !prefixed) begin
          prefixed = 1'b1;
          return;
        end
        insn[0] = b;
        e = len_entry(b);
        if (e == 4'd0) begin
          need = 1;
          finish_insn(1'b0);
          return;
        end
        need  = e[3] ? 16 - int'(e) : int'(e);
        phase = 1;
      end else begin
        insn[phase % 8] = b;
        cur_addr = cur_addr + 16'd1;
        e = len_entry(insn[0]);
        if (phase == 1 && e[3] && b[0]) need++;
        phase++;
      end
      if (phase >= need || phase >= 8) finish_insn(1'b1);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_record(insn_record_t got);
      insn_record_t want;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: record with no instruction pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_records.pop_front();
      check_field("insn_address", want.insn_address, got.insn_address);
      check_field("opcode_value", want.opcode, got.opcode);
      check_field("signed_prefix", want.prefixed, got.prefixed);
      check_field("total_length", want.length, got.length);
      check_field("known_opcode", want.known, got.known);
      check_field("opcode_group", want.grp, got.grp);
      check_field("address_mode", want.mode, got.mode);
      check_field("byte_operation", want.byte_op, got.byte_op);
      check_field("reference_kind", want.kind, got.kind);
      check_field("reference_value", want.value, got.value);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  code_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] insn_address_o;
  logic [7:0]  opcode_value_o;
  logic        signed_prefix_o;
  logic [3:0]  total_length_o;
  logic        known_opcode_o;
  logic [3:0]  opcode_group_o;
  logic [1:0]  address_mode_o;
  logic        byte_operation_o;
  logic [2:0]  reference_kind_o;
  logic [15:0] reference_value_o;

  insn_record_scoreboard sb = new();
  logic [7:0] code_stream[$];
  bit         calm = 1'b0;   // set for a stretch with no gaps and no stalls
  int         quiet = 0;

  insn_length_and_target_predecoder_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .code_byte_i       (code_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .insn_address_o    (insn_address_o),
    .opcode_value_o    (opcode_value_o),
    .signed_prefix_o   (signed_prefix_o),
    .total_length_o    (total_length_o),
    .known_opcode_o    (known_opcode_o),
    .opcode_group_o    (opcode_group_o),
    .address_mode_o    (address_mode_o),
    .byte_operation_o  (byte_operation_o),
    .reference_kind_o  (reference_kind_o),
    .reference_value_o (reference_value_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The receiver stalls in about a third of the cycles. The stall changes at
  // the falling edge, so it is stable at the rising edge that samples it.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 35);
  end

  // Every record transaction is checked against the oldest pending record.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_record('{insn_address_o, opcode_value_o, signed_prefix_o, total_length_o,
                        known_opcode_o, iltp_pkg::grp_e'(opcode_group_o),
                        address_mode_o, byte_operation_o,
                        iltp_pkg::ref_e'(reference_kind_o), reference_value_o});
    end
  end

  // Watchdog: a long run of cycles with no transaction on either channel
  // means the block has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One APB transfer: a setup cycle, then the access cycle that completes at
  // the rising edge where pready is high. A write of the start address also
  // restarts the prediction; a read is compared with the predicted register.
  task automatic apb_access(input bit write, input logic [2:0] addr,
                            input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (write) begin
      if (addr == AddrStartAddress) sb.write_start(data[15:0]);
    end else if (prdata[15:0] !== sb.start_addr) begin
      sb.errors++;
      $display("%0t: start_address readback mismatch, expected %h, actual %h",
               $time, sb.start_addr, prdata[15:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sends the queued code bytes, one transaction each, with random gaps in
  // which the byte lines carry junk. A byte stays on the lines until taken.
  task automatic send_code_stream();
    logic [7:0] b;
    while (code_stream.size() != 0) begin
      b = code_stream.pop_front();
      @(negedge clk_i);
      while (!calm && $urandom_range(99) < 35) begin
        in_valid_i  <= 1'b0;
        code_byte_i <= 8'($urandom_range(255));
        @(negedge clk_i);
      end
      in_valid_i  <= 1'b1;
      code_byte_i <= b;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_code_byte(b);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Queues mostly well-formed instructions with random operand bytes: an
  // optional prefix, an opcode that is often one of the special ones, and as
  // many bytes as the length table asks, honoring the odd second byte rule.
  // A share of lone random bytes knocks the stream off its boundaries.
  task automatic add_random_code(input int count);
    logic [7:0] op;
    logic [7:0] b;
    logic [3:0] e;
    int         n;
    int         i;
    int         k;
    while (code_stream.size() < count) begin
      if ($urandom_range(99) < 15) begin
        code_stream.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < 12) code_stream.push_back(iltp_pkg::PrefixByte);
        if ($urandom_range(99) < 30) begin
          k  = $urandom_range(NumHotOps - 1);
          op = HotOps[8*k +: 8];
        end else begin
          op = 8'($urandom_range(255));
        end
        code_stream.push_back(op);
        e = insn_record_scoreboard::len_entry(op);
        n = (e == 4'd0) ? 1 : (e[3] ? 16 - int'(e) : int'(e));
        i = 1;
        while (i < n) begin
          b = 8'($urandom_range(255));
          code_stream.push_back(b);
          if (i == 1 && e[3] && b[0]) n++;
          i++;
        end
      end
    end
  endtask

  // Waits until every predicted record has arrived, then lets the pipeline
  // settle: a partial instruction may still be in flight without a record.
  task automatic drain();
    while (sb.pending_records.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The start address sits just below the top so that the
    // first instructions wrap around; the upper data bits must be dropped
    // and a write to the unmapped address must be ignored.
    apb_access(1'b1, AddrStartAddress, 32'hABCD_FFFE);
    apb_access(1'b1, AddrUnmapped, 32'h0000_1234);
    apb_access(1'b0, AddrStartAddress, '0);
    code_stream = '{
      8'h27, 8'hFF,                               // sjmp, negative 11-bit offset
      8'hFE, 8'hFE, 8'h01, 8'h02, 8'h03, 8'h04,   // prefix twice: nine bytes
      8'h05, 8'h06, 8'h07,
      8'h10,                                      // unknown opcode
      8'hFE, 8'hF1,                               // prefixed unknown opcode
      8'hE7, 8'h00, 8'h80,                        // ljmp, 16-bit displacement
      8'h43, 8'h01, 8'hCD, 8'hAB, 8'h11,          // long indexed pointer word
      8'hDF, 8'h80,                               // last indexed byte (odd second byte), then 0x80
      8'hFF                                       // operand of 0x80, which stays unfinished
    };
    send_code_stream();
    drain();

    // Random part with gaps and stalls from a random start address.
    apb_access(1'b1, AddrStartAddress, $urandom);
    apb_access(1'b0, AddrStartAddress, '0);
    add_random_code(300);
    send_code_stream();
    drain();

    // A long stretch at full rate on both channels from address zero.
    calm = 1'b1;
    apb_access(1'b1, AddrStartAddress, 32'h0000_0000);
    add_random_code(300);
    send_code_stream();
    drain();
    calm = 1'b0;

    // Gaps and stalls again from the top address.
    apb_access(1'b1, AddrStartAddress, 32'h0000_FFFF);
    apb_access(1'b0, AddrStartAddress, '0);
    add_random_code(325);
    send_code_stream();
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/iltp_pkg.sv
hdl/insn_length_and_target_predecoder_unit.sv
tb/sv/tb_insn_length_and_target_predecoder_unit.sv
